[rtl/min_priority_queue_defines.svh]
// Assertion macros used by the checker file.
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define MPQ_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mpq_pkg.sv]
`default_nettype none

package mpq_pkg;

  // Queue depth; one cell per entry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OCC_W    = 7;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Operation broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [KEY_W-1:0] key;
  } cell_op_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    valid;
    logic                    gt;    // new key sorts before this entry
  } cell_link_t;

endpackage

`default_nettype wire

[rtl/mpq_req_if.sv]
`default_nettype none

interface mpq_req_if import mpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

`default_nettype wire

[rtl/mpq_rsp_if.sv]
`default_nettype none

interface mpq_rsp_if import mpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] removed_key;
  logic signed [KEY_W-1:0] head_key;
  logic [OCC_W-1:0]        occupancy;
  logic [1:0]              status;

  modport source (output valid, output removed_key, output head_key, output occupancy,
                  output status, input ready);
  modport sink   (input valid, input removed_key, input head_key, input occupancy,
                  input status, output ready);
endinterface

`default_nettype wire

[rtl/mpq_cell.sv]
`default_nettype none

// One slot of the sorted chain. Cell 0 holds the smallest key.
module mpq_cell import mpq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_op_t   op_i,
  input  wire cell_link_t left_i,
  input  wire cell_link_t right_i,
  output cell_link_t      self_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    valid_q, valid_d;
  logic                    gt;

  // Insert lands before the first entry that is larger (after equal keys)
  assign gt = !valid_q || (op_i.key < key_q);

  // Next value: keep, take the new key, or shift from a neighbor
  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (op_i.ins && gt) begin
      if (!left_i.gt) begin
        key_d   = op_i.key;
        valid_d = 1'b1;
      end else begin
        key_d   = left_i.key;
        valid_d = left_i.valid;
      end
    end else if (op_i.del) begin
      key_d   = right_i.key;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign self_o = '{key: key_q, valid: valid_q, gt: gt};

endmodule

`default_nettype wire

[rtl/min_priority_queue.sv]
// Latency: a request accepted at one edge shows its response from the next cycle on.
// Throughput: one request per cycle; every cell compares and shifts in the same edge.
// A request waits only while an earlier response is held by the sink.
// Reset: asynchronous, active low; empties the chain and clears the response.
`default_nettype none

module min_priority_queue import mpq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpq_req_if.sink   req_i,
  mpq_rsp_if.source rsp_o
);

  cell_link_t              links [CAPACITY];
  cell_link_t              left_edge, right_edge;
  cell_op_t                op;
  logic                    accept, full, empty;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    rsp_valid_q;
  logic signed [KEY_W-1:0] removed_q, removed_d;
  status_e                 status_q, status_d;

  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);
  assign accept = req_i.valid && req_i.ready;

  // Chain boundaries: nothing to the left sorts after the key, nothing valid at the right
  assign left_edge  = '{key: '0, valid: 1'b1, gt: 1'b0};
  assign right_edge = '{key: '0, valid: 1'b0, gt: 1'b1};

  // Request decode
  always_comb begin
    op.ins    = 1'b0;
    op.del    = 1'b0;
    op.key    = req_i.key;
    count_d   = count_q;
    removed_d = removed_q;
    status_d  = status_q;
    if (accept) begin
      removed_d = '0;
      status_d  = ST_OK;
      if (req_i.action == ACT_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op.ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          op.del    = 1'b1;
          removed_d = links[0].key;
          count_d   = count_q - 1'b1;
        end
      end
    end
  end

  // Sorted chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_cell u_cell (
      .clk_i,
      .rst_ni,
      .op_i    (op),
      .left_i  ((i == 0) ? left_edge : links[(i == 0) ? 0 : i - 1]),
      .right_i ((i == CAPACITY - 1) ? right_edge : links[(i == CAPACITY - 1) ? i : i + 1]),
      .self_o  (links[i])
    );
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
  end

  // Chain only moves on an accepted request, so head and count hold while stalled
  assign req_i.ready       = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.removed_key = removed_q;
  assign rsp_o.head_key    = links[0].valid ? links[0].key : '0;
  assign rsp_o.occupancy   = OCC_W'(count_q);
  assign rsp_o.status      = status_q;

endmodule

`default_nettype wire

[rtl/mpq_checker.sv]
`default_nettype none

`include "min_priority_queue_defines.svh"

module mpq_checker import mpq_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    rsp_valid_i,
  input wire logic                    rsp_ready_i,
  input wire logic signed [KEY_W-1:0] removed_key_i,
  input wire logic signed [KEY_W-1:0] head_key_i,
  input wire logic [OCC_W-1:0]        occupancy_i,
  input wire logic [1:0]              status_i
);

  // A held response does not change
  `MPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(removed_key_i) && $stable(head_key_i) && $stable(occupancy_i) && $stable(status_i), "response changed while stalled")

  // Failed delete-min leaves an empty queue and reports zeros
  `MPQ_ASSERT(a_empty_del, !(rsp_valid_i && status_i == ST_EMPTY) || (occupancy_i == '0 && head_key_i == '0 && removed_key_i == '0), "bad empty delete-min response")

  // Dropped insert only happens when full
  `MPQ_ASSERT(a_full_drop, !(rsp_valid_i && status_i == ST_FULL) || (occupancy_i == OCC_W'(CAPACITY) && removed_key_i == '0), "insert dropped while not full")

  // An empty queue shows a zero head
  `MPQ_ASSERT(a_empty_head, !(rsp_valid_i && occupancy_i == '0) || head_key_i == '0, "nonzero head on empty queue")

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .removed_key_i (rsp_o.removed_key),
  .head_key_i    (rsp_o.head_key),
  .occupancy_i   (rsp_o.occupancy),
  .status_i      (rsp_o.status)
);

`default_nettype wire
